// ===== design/cfe_pkg.sv =====
// Shared constants and types of the continued fraction expansion block.
package cfe_pkg;

   localparam int WIDTH       = 32;
   localparam int FIELD_W     = 32;
   localparam int TERM_W      = 32;
   localparam int IN_DATA_W   = 2 * FIELD_W;
   localparam int MAX_TERMS   = 48;
   localparam int TERM_CNT_W  = $clog2(MAX_TERMS);
   localparam int STEP_CNT_W  = $clog2(WIDTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [WIDTH-1:0]   operand_type;
   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [TERM_W-1:0]  term_type;

   typedef struct packed {
      operand_type dividend;
      operand_type divisor;
      logic        zero_div;
   } job_type;

   typedef struct packed {
      term_type term;
      logic     last;
      logic     error;
   } result_type;

endpackage

// ===== design/cfe_front.sv =====
// Front end: takes fraction beats, trims operands and flags a zero denominator.
module cfe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [cfe_pkg::IN_DATA_W-1:0] req_tdata,
   output logic                    job_valid,
   input  logic                    job_ready,
   output cfe_pkg::job_type        job
);
   import cfe_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   operand_type num, den;

   assign num = WIDTH'(req_tdata[FIELD_W-1:0]);
   assign den = WIDTH'(req_tdata[IN_DATA_W-1:FIELD_W]);

   assign req_tready = !valid_ff || job_ready;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (valid_ff && job_ready) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in        = 1'b1;
         job_in.dividend = num;
         job_in.divisor  = den;
         job_in.zero_div = (den == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

// ===== design/cfe_queue.sv =====
// Short job queue between the front end and the Euclid engine.
module cfe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cfe_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cfe_pkg::job_type pop_job
);
   import cfe_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_job    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/cfe_back.sv =====
// Euclid engine: bit-serial restoring divider and term output register.
module cfe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  cfe_pkg::job_type        job,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output cfe_pkg::result_type     rsp
);
   import cfe_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT,
      ST_FAULT
   } state_type;

   state_type             state_ff, state_in;
   operand_type           rem_ff, rem_in;
   operand_type           quo_ff, quo_in;
   operand_type           divisor_ff, divisor_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic [TERM_CNT_W-1:0] nterm_ff, nterm_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff, out_in;
   logic [WIDTH:0]        trial;
   logic                  out_free, last_term;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign trial     = {rem_ff, quo_ff[WIDTH-1]} - {1'b0, divisor_ff};
   assign last_term = (rem_ff == '0) || (nterm_ff == TERM_CNT_W'(MAX_TERMS - 1));
   assign job_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      nterm_in     = nterm_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               rem_in     = '0;
               quo_in     = job.dividend;
               divisor_in = job.divisor;
               step_in    = '0;
               nterm_in   = '0;
               state_in   = job.zero_div ? ST_FAULT : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!trial[WIDTH]) begin
               rem_in = trial[WIDTH-1:0];
            end else begin
               rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            end
            quo_in  = {quo_ff[WIDTH-2:0], !trial[WIDTH]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(WIDTH - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.term  = TERM_W'(quo_ff);
               out_in.last  = last_term;
               out_in.error = 1'b0;
               if (last_term) begin
                  state_in = ST_IDLE;
               end else begin
                  quo_in     = divisor_ff;
                  divisor_in = rem_ff;
                  rem_in     = '0;
                  step_in    = '0;
                  nterm_in   = nterm_ff + 1'b1;
                  state_in   = ST_DIVIDE;
               end
            end
         end
         ST_FAULT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.term  = '0;
               out_in.last  = 1'b1;
               out_in.error = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
         nterm_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         nterm_ff     <= nterm_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp        = out_ff;

endmodule

// ===== design/continued_fraction_expansion.sv =====
// Top level of the continued fraction expansion block.
//
//   channel  dir  beat contents
//   req_     in   tdata[31:0] numerator, tdata[63:32] denominator
//   rsp_     out  tdata[31:0] term, tlast final term, tuser[0] zero-denominator error
//
// Each Euclid step runs the bit-serial divider over WIDTH quotient bits and then
// issues the term, waiting while the output register is full. The engine emits
// at most MAX_TERMS (48) terms per fraction, the last one flagged; a zero
// denominator yields a single error beat.
// Reset clears the front register, the queue pointers and the engine state.
// The front end and a two-deep queue keep taking fractions, until they are full, while the engine or
// the output register is stalled; the engine holds a term until rsp_tready.
module continued_fraction_expansion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] numerator, [63:32] denominator
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] term
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] error
);
   import cfe_pkg::*;

   logic       fq_valid, fq_ready;
   job_type    fq_job;
   logic       qb_valid, qb_ready;
   job_type    qb_job;
   result_type rsp;

   cfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job        (fq_job)
   );

   cfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   cfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_ready  (qb_ready),
      .job        (qb_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = rsp.term;
   assign rsp_tlast = rsp.last;
   assign rsp_tuser = rsp.error;

endmodule
